FILE: rtl/ptrm_pkg.sv
package ptrm_pkg;

   // Block configuration
   localparam int NUM_TYPES = 8;
   localparam int DATA_BITS = 32;

   // Fixed field widths
   localparam int FRAME_W   = 32;
   localparam int TYPE_W    = 3;
   localparam int WORD_W    = 32;
   localparam int SPACING_W = 16;

   // Configuration register file
   localparam int CSR_COUNT        = 8;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_SPACING_BASE = 0;

   // Derived widths
   localparam int SLOT_W      = $clog2(NUM_TYPES);
   localparam int PAYLOAD_W   = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;
   localparam int REQ_FIELD_W = FRAME_W + TYPE_W + WORD_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = TYPE_W + FRAME_W + WORD_W + WORD_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Item kind carried on the request tuser
   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   // One run slot as kept in the slot memory; last is start + length - 1.
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [FRAME_W-1:0]   last;
      logic [WORD_W-1:0]    length;
      logic [FRAME_W-1:0]   start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Outcome of checking an event against its open run
   typedef struct packed {
      logic close;
      logic stretch;
   } verdict_type;

endpackage

FILE: rtl/ptrm_ram.sv
module ptrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single write port, registered read port; a read sees writes of earlier edges.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ptrm_csr.sv
module ptrm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ptrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptrm_pkg::SPACING_W-1:0] csr_wdata,
   input  logic [ptrm_pkg::SLOT_W-1:0]    slot,
   output logic [ptrm_pkg::SPACING_W-1:0] spacing
);

   import ptrm_pkg::*;

   logic [SPACING_W-1:0] spacing_ff [CSR_COUNT];
   logic [SPACING_W-1:0] spacing_in [CSR_COUNT];

   // Register write decode.
   always_comb begin
      for (int i = 0; i < CSR_COUNT; i++) begin
         spacing_in[i] = spacing_ff[i];
         if (csr_we && (csr_index == CSR_IDX_W'(CSR_SPACING_BASE + i))) begin
            spacing_in[i] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            spacing_ff[i] <= SPACING_W'(1);
         end
      end else begin
         spacing_ff <= spacing_in;
      end
   end

   // Spacing of the slot under evaluation.
   assign spacing = spacing_ff[slot];

endmodule

FILE: rtl/ptrm_eval.sv
module ptrm_eval (
   input  ptrm_pkg::entry_type              cur,
   input  logic [ptrm_pkg::FRAME_W-1:0]     frame,
   input  logic [ptrm_pkg::PAYLOAD_W-1:0]   data,
   input  logic [ptrm_pkg::SPACING_W-1:0]   spacing,
   output ptrm_pkg::verdict_type            verdict,
   output ptrm_pkg::entry_type              stretched
);

   import ptrm_pkg::*;

   logic [FRAME_W:0] thr;
   logic [FRAME_W:0] span;
   logic             sat;

   // The run closes once the event reaches last frame plus spacing, or on new data.
   assign thr           = {1'b0, cur.last} + (FRAME_W + 1)'(spacing);
   assign verdict.close = (thr <= {1'b0, frame}) || (cur.payload != data);

   // Only an event past the run's last frame moves the end.
   assign verdict.stretch = !verdict.close && (frame > cur.last);

   // New length counts both ends; it tops out only for a run over the whole frame range.
   assign span = {1'b0, frame} - {1'b0, cur.start} + (FRAME_W + 1)'(1);
   assign sat  = span[FRAME_W];

   always_comb begin
      stretched         = cur;
      stretched.length  = sat ? {WORD_W{1'b1}} : span[WORD_W-1:0];
      stretched.last    = sat ? {{(FRAME_W - 1){1'b1}}, 1'b0} : frame;
   end

endmodule

FILE: rtl/per_type_event_run_merger.sv
// Event: the item is taken in ST_IDLE, its slot is read and written back in ST_EVAL, which
// waits for the output register when the run closes; the closed run is emitted through it.
// Flush: ST_IDLE fetches the first open slot, then ST_FLUSH emits one run per cycle while rsp
// takes them; an empty flush stays in ST_IDLE. The slot memory's registered read sets this
// order. Reset (synchronous) closes all runs, sets every spacing to 1 and empties the output
// register; the slot memory needs no clearing pass.
module per_type_event_run_merger (
   input  logic                             clock,
   input  logic                             reset,
   // Request: [31:0] event_frame, [34:32] event_type, [66:35] event_data
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ptrm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,    // op
   // Response: [2:0] run_type, [34:3] run_start_frame, [66:35] run_duration,
   // [98:67] run_data
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ptrm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,    // last_of_flush
   input  logic                             csr_we,
   input  logic [ptrm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptrm_pkg::SPACING_W-1:0]   csr_wdata
);

   import ptrm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [NUM_TYPES-1:0] open_ff, open_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [PAYLOAD_W-1:0] data_ff, data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            rsp_entry_ff, rsp_entry_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [FRAME_W-1:0]   req_frame;
   logic [TYPE_W-1:0]    req_type;
   logic [WORD_W-1:0]    req_data;
   logic                 req_acc;
   logic                 type_ok;
   logic                 out_free;
   logic                 any_open;
   logic [SLOT_W-1:0]    first_slot;
   logic [SLOT_W-1:0]    next_slot;
   logic [SLOT_W-1:0]    last_slot;

   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_raddr;
   entry_type            ram_wdata;
   entry_type            cur;
   entry_type            fresh;
   entry_type            stretched;
   verdict_type          verdict;
   logic [SPACING_W-1:0] spacing;

   // Request fields
   assign req_frame = req_tdata[FRAME_W-1:0];
   assign req_type  = req_tdata[FRAME_W +: TYPE_W];
   assign req_data  = req_tdata[FRAME_W + TYPE_W +: WORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign type_ok    = int'(req_type) < NUM_TYPES;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign any_open   = |open_ff;

   // Open-slot search for the flush sequence.
   always_comb begin
      first_slot = '0;
      next_slot  = '0;
      last_slot  = '0;
      for (int i = NUM_TYPES - 1; i >= 0; i--) begin
         if (open_ff[i]) begin
            first_slot = SLOT_W'(i);
         end
         if (open_ff[i] && (i > int'(slot_ff))) begin
            next_slot = SLOT_W'(i);
         end
      end
      for (int i = 0; i < NUM_TYPES; i++) begin
         if (open_ff[i]) begin
            last_slot = SLOT_W'(i);
         end
      end
   end

   // Slot memory holding start, length, last frame and payload of each run.
   ptrm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TYPES)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (cur)
   );

   ptrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .slot      (slot_ff),
      .spacing   (spacing)
   );

   ptrm_eval u_eval (
      .cur       (cur),
      .frame     (frame_ff),
      .data      (data_ff),
      .spacing   (spacing),
      .verdict   (verdict),
      .stretched (stretched)
   );

   // A run opened by the current event.
   always_comb begin
      fresh.start   = frame_ff;
      fresh.length  = WORD_W'(1);
      fresh.last    = frame_ff;
      fresh.payload = data_ff;
   end

   // Sequencer: read the slot, then decide, write back and emit.
   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      slot_in      = slot_ff;
      frame_in     = frame_ff;
      data_in      = data_ff;
      ram_raddr    = slot_ff;
      ram_we       = 1'b0;
      ram_wdata    = fresh;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_entry_in = rsp_entry_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_FLUSH) begin
                  if (any_open) begin
                     slot_in   = first_slot;
                     ram_raddr = first_slot;
                     state_in  = ST_FLUSH;
                  end
               end else if (type_ok) begin
                  slot_in   = req_type[SLOT_W-1:0];
                  ram_raddr = req_type[SLOT_W-1:0];
                  frame_in  = req_frame;
                  data_in   = req_data[PAYLOAD_W-1:0];
                  state_in  = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (!open_ff[slot_ff]) begin
               // No run yet: open one.
               ram_we           = 1'b1;
               open_in[slot_ff] = 1'b1;
               state_in         = ST_IDLE;
            end else if (verdict.close) begin
               // Emit the old run, then replace it; waits for the output register.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = cur;
                  rsp_slot_in  = slot_ff;
                  rsp_last_in  = 1'b0;
                  ram_we       = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               ram_we    = verdict.stretch;
               ram_wdata = stretched;
               state_in  = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_entry_in     = cur;
               rsp_slot_in      = slot_ff;
               rsp_last_in      = (slot_ff == last_slot);
               open_in[slot_ff] = 1'b0;
               if (slot_ff == last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in   = next_slot;
                  ram_raddr = next_slot;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and output payload
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      frame_ff     <= frame_in;
      data_ff      <= data_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({WORD_W'(rsp_entry_ff.payload),
                                     rsp_entry_ff.length,
                                     rsp_entry_ff.start,
                                     TYPE_W'(rsp_slot_ff)});

endmodule

FILE: rtl/ptrm_checker.sv
module ptrm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ptrm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   import ptrm_pkg::*;

   // A stalled response transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // An accepted event always occupies the block for its slot evaluation.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_EVENT) |=> !req_tready)
      else $error("event accepted without evaluation cycle");

   // A new response is only produced while the block is busy with an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared while idle");

   // Reset leaves the output empty and the input open.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind per_type_event_run_merger ptrm_checker u_ptrm_checker (.*);
